// ===== rtl/core/backslash_escape_decoder_defines.svh =====
// Assertion macros used by the checker file of the escape decoder.
`ifndef BACKSLASH_ESCAPE_DECODER_DEFINES_SVH
`define BACKSLASH_ESCAPE_DECODER_DEFINES_SVH

// Overlapping implication, sampled on the rising clock edge outside reset.
`define BED_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, sampled on the rising clock edge outside reset.
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bed_pkg.sv =====
`timescale 1ns / 1ps

package bed_pkg;

  // Width of one text byte, most bytes in one decoded group and width of its count.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxRes = 3;
  localparam int unsigned CntW   = 2;

  // Character codes recognized by the decoder.
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChX      = 8'h78;
  localparam logic [ByteW-1:0] Ch0      = 8'h30;
  localparam logic [ByteW-1:0] Ch7      = 8'h37;
  localparam logic [ByteW-1:0] Ch9      = 8'h39;
  localparam logic [ByteW-1:0] ChLa     = 8'h61;
  localparam logic [ByteW-1:0] ChLf     = 8'h66;
  localparam logic [ByteW-1:0] ChUa     = 8'h41;
  localparam logic [ByteW-1:0] ChUf     = 8'h46;

  // One queue entry: the decoded bytes of one input word, lowest index first.
  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]              cnt;
    logic                         last;
  } entry_t;

endpackage

// ===== rtl/core/bed_front.sv =====
`timescale 1ns / 1ps

module bed_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  input  logic             q_full_i,
  output logic             push_o,
  output bed_pkg::entry_t  entry_o
);
  import bed_pkg::*;

  // Escape parser state codes.
  localparam logic [2:0] ModeText = 3'd0;
  localparam logic [2:0] ModeEsc  = 3'd1;
  localparam logic [2:0] ModeHex1 = 3'd2;
  localparam logic [2:0] ModeHex2 = 3'd3;
  localparam logic [2:0] ModeOct  = 3'd4;

  // Letters a-f and A-F carry their value minus nine in the low nibble.
  localparam logic [3:0] HexLetterOfs = 4'd9;

  logic [2:0]       mode_q, mode_d;
  logic [ByteW-1:0] acc_q, acc_d;
  logic [1:0]       dl_q, dl_d;

  logic             accept;
  logic             hex_ok;
  logic [3:0]       hex_v;
  logic             oct_ok;
  logic             plain_emit;
  logic [2:0]       plain_mode;
  logic [ByteW-1:0] oct_acc;
  logic [1:0]       oct_dl;
  entry_t           ent;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Character classification.
  always_comb begin
    hex_ok = 1'b0;
    hex_v  = in_byte_i[3:0];
    if (in_byte_i inside {[Ch0:Ch9]}) begin
      hex_ok = 1'b1;
    end else if (in_byte_i inside {[ChLa:ChLf], [ChUa:ChUf]}) begin
      hex_ok = 1'b1;
      hex_v  = in_byte_i[3:0] + HexLetterOfs;
    end
  end

  assign oct_ok     = in_byte_i inside {[Ch0:Ch7]};
  assign plain_emit = !((in_byte_i == ChBslash) && !in_last_i);
  assign plain_mode = plain_emit ? ModeText : ModeEsc;
  assign oct_acc    = {acc_q[4:0], in_byte_i[2:0]};
  assign oct_dl     = dl_q - 2'd1;

  // Decode one word into up to three bytes and the next parser state.
  always_comb begin
    mode_d          = mode_q;
    acc_d           = acc_q;
    dl_d            = dl_q;
    ent.bytes[0]    = in_byte_i;
    ent.bytes[1]    = in_byte_i;
    ent.bytes[2]    = in_byte_i;
    ent.cnt         = 2'd0;
    ent.last        = in_last_i;

    case (mode_q)
      ModeEsc: begin
        if (in_byte_i == ChX) begin
          if (in_last_i) begin
            ent.bytes[0] = ChBslash;
            ent.cnt      = 2'd2;
            mode_d       = ModeText;
          end else begin
            mode_d = ModeHex1;
          end
        end else if (oct_ok) begin
          acc_d = {5'd0, in_byte_i[2:0]};
          dl_d  = (in_byte_i == Ch0) ? 2'd3 : 2'd2;
          if (in_last_i) begin
            ent.bytes[0] = {5'd0, in_byte_i[2:0]};
            ent.cnt      = 2'd1;
            mode_d       = ModeText;
          end else begin
            mode_d = ModeOct;
          end
        end else if (in_byte_i == ChBslash) begin
          ent.cnt = 2'd1;
          mode_d  = ModeText;
        end else begin
          // Unknown escape keeps the backslash in front of the character.
          ent.bytes[0] = ChBslash;
          ent.cnt      = 2'd2;
          mode_d       = ModeText;
        end
      end
      ModeHex1: begin
        if (hex_ok) begin
          acc_d = {4'd0, hex_v};
          if (in_last_i) begin
            ent.bytes[0] = {4'd0, hex_v};
            ent.cnt      = 2'd1;
            mode_d       = ModeText;
          end else begin
            mode_d = ModeHex2;
          end
        end else begin
          // No hex digit: give back the backslash and the x, then plain text.
          ent.bytes[0] = ChBslash;
          ent.bytes[1] = ChX;
          ent.cnt      = plain_emit ? 2'd3 : 2'd2;
          mode_d       = plain_mode;
        end
      end
      ModeHex2: begin
        if (hex_ok) begin
          ent.bytes[0] = {acc_q[3:0], hex_v};
          ent.cnt      = 2'd1;
          mode_d       = ModeText;
        end else begin
          ent.bytes[0] = acc_q;
          ent.cnt      = plain_emit ? 2'd2 : 2'd1;
          mode_d       = plain_mode;
        end
      end
      ModeOct: begin
        if (oct_ok && (dl_q != 2'd0)) begin
          acc_d = oct_acc;
          dl_d  = oct_dl;
          if ((oct_dl == 2'd0) || in_last_i) begin
            ent.bytes[0] = oct_acc;
            ent.cnt      = 2'd1;
            mode_d       = ModeText;
          end
        end else begin
          ent.bytes[0] = acc_q;
          ent.cnt      = plain_emit ? 2'd2 : 2'd1;
          mode_d       = plain_mode;
        end
      end
      default: begin
        ent.cnt = plain_emit ? 2'd1 : 2'd0;
        mode_d  = plain_mode;
      end
    endcase

    // Back in text or at the end of the text the escape state starts over.
    if ((mode_d == ModeText) || in_last_i) begin
      mode_d = ModeText;
      acc_d  = '0;
      dl_d   = 2'd0;
    end
  end

  assign push_o  = accept && (ent.cnt != 2'd0);
  assign entry_o = ent;

  // Parser state advances on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeText;
      acc_q  <= '0;
      dl_q   <= 2'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      dl_q   <= dl_d;
    end
  end

endmodule

// ===== rtl/core/bed_queue.sv =====
`timescale 1ns / 1ps

module bed_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bed_pkg::entry_t  push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output bed_pkg::entry_t  head_entry_o
);
  import bed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = store_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset; the fill count guards it.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/core/bed_back.sv =====
`timescale 1ns / 1ps

module bed_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  bed_pkg::entry_t  head_entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_run_last_o,
  output logic             out_text_end_o
);
  import bed_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             run_last_q, run_last_d;
  logic             text_end_q, text_end_d;
  logic [1:0]       idx_q, idx_d;
  logic             load;
  logic             at_end;

  // The output register takes a new word when empty or when its word leaves.
  assign load   = !valid_q || out_ready_i;
  assign at_end = (idx_q == (head_entry_i.cnt - 2'd1));
  assign pop_o  = load && head_valid_i && at_end;

  always_comb begin
    valid_d    = valid_q;
    byte_d     = byte_q;
    run_last_d = run_last_q;
    text_end_d = text_end_q;
    idx_d      = idx_q;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        byte_d     = head_entry_i.bytes[idx_q];
        run_last_d = at_end;
        text_end_d = at_end && head_entry_i.last;
        idx_d      = at_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    run_last_q <= run_last_d;
    text_end_q <= text_end_d;
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign out_run_last_o = run_last_q;
  assign out_text_end_o = text_end_q;

endmodule

// ===== rtl/core/backslash_escape_decoder.sv =====
// The decoded bytes of an input word pass through the queue and then the output register to m_axis.
// Throughput: one input word per cycle while each decodes to at most one byte and the queue is not full.
// A word that decodes to two or three bytes leaves the serializer as that many output words.
// The queue between parser and serializer absorbs these bursts up to QueueDepth entries.
// Reset is asynchronous and active low; it clears the parser, queue and output at once.
`timescale 1ns / 1ps

module backslash_escape_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // is_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // run_last
  output logic       m_axis_tuser    // [0] text_end
);
  import bed_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  logic   head_valid;
  entry_t head_entry;

  // Parser: takes text words and turns them into groups of decoded bytes.
  bed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue of decoded groups.
  bed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  // Serializer: sends the bytes of each group one word at a time.
  bed_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_entry_i   (head_entry),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (m_axis_tdata),
    .out_run_last_o (m_axis_tlast),
    .out_text_end_o (m_axis_tuser)
  );

endmodule

// ===== rtl/core/bed_checker.sv =====
`timescale 1ns / 1ps
`include "backslash_escape_decoder_defines.svh"

module bed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // A stalled input word keeps its payload.
  `BED_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast), "input word changed while stalled")

  // A stalled output word keeps its payload.
  `BED_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output word changed while stalled")

  // The end of the text is always the last byte of its group.
  `BED_ASSERT_SAME(a_end_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "text end without group end")

  // The rest of a group follows without a gap.
  `BED_ASSERT_NEXT(a_group_cont, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside a decoded group")

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
